FILE: design/hsdf_pkg.sv
// Package for the hall speed and direction filter: sizes, microcode table, hall helpers.
`timescale 1ns / 1ps
`default_nettype none

package hsdf_pkg;

   localparam int FILTER_DEPTH = 8;

   // Magnitude of a ring sum fits below FILTER_DEPTH * 2^31.
   localparam int MAG_W  = 31 + $clog2(FILTER_DEPTH);
   localparam int ACC_W  = MAG_W + 1;
   localparam int IDX_W  = $clog2(FILTER_DEPTH);
   localparam int CNT_W  = $clog2(FILTER_DEPTH + 1);
   localparam int ITER_W = $clog2(MAG_W);
   localparam int STEP_W = 4;

   localparam logic [31:0] SCALE_RESET = 32'd5000000;
   localparam logic [30:0] SAT31       = 31'h7FFF_FFFF;

   localparam logic [STEP_W-1:0] STEP_IDLE      = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_SPEED_DIV = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_STORE     = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_READ      = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_ACC       = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_LOAD_MEAN = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_MEAN_DIV  = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_WAIT_OUT  = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_FINISH    = STEP_W'(8);

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD_SPEED,
      OP_DIV_STEP,
      OP_STORE,
      OP_READ,
      OP_ACC,
      OP_LOAD_MEAN,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DIV_MORE,
      COND_SUM_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // Control store: one word per step, jump to target when cond holds.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE:      w = '{op: OP_LOAD_SPEED, cond: COND_NO_REQ,   target: STEP_IDLE};
         STEP_SPEED_DIV: w = '{op: OP_DIV_STEP,   cond: COND_DIV_MORE, target: STEP_SPEED_DIV};
         STEP_STORE:     w = '{op: OP_STORE,      cond: COND_NONE,     target: STEP_IDLE};
         STEP_READ:      w = '{op: OP_READ,       cond: COND_NONE,     target: STEP_IDLE};
         STEP_ACC:       w = '{op: OP_ACC,        cond: COND_SUM_MORE, target: STEP_READ};
         STEP_LOAD_MEAN: w = '{op: OP_LOAD_MEAN,  cond: COND_NONE,     target: STEP_IDLE};
         STEP_MEAN_DIV:  w = '{op: OP_DIV_STEP,   cond: COND_DIV_MORE, target: STEP_MEAN_DIV};
         STEP_WAIT_OUT:  w = '{op: OP_NOP,        cond: COND_OUT_BUSY, target: STEP_WAIT_OUT};
         STEP_FINISH:    w = '{op: OP_FINISH,     cond: COND_ALWAYS,   target: STEP_IDLE};
         default:        w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

   // Position in the sequence 1,3,2,6,4,5; invalid codes give 6.
   function automatic logic [2:0] hall_position(input logic [2:0] code);
      logic [2:0] p;
      p = 3'd6;
      unique case (code)
         3'd1:    p = 3'd0;
         3'd3:    p = 3'd1;
         3'd2:    p = 3'd2;
         3'd6:    p = 3'd3;
         3'd4:    p = 3'd4;
         3'd5:    p = 3'd5;
         default: p = 3'd6;
      endcase
      return p;
   endfunction

   function automatic logic sign_negative(input logic [2:0] pos, input logic [2:0] last);
      logic neg;
      priority if (pos == 3'd0) begin
         neg = (last == 3'd5);
      end else if (pos == 3'd5) begin
         neg = (last == 3'd4);
      end else begin
         neg = (pos > last);
      end
      return neg;
   endfunction

endpackage

`default_nettype wire

FILE: design/hall_speed_direction_filter_unit.sv
// Hall edge to filtered signed rpm: microcoded sequencer around a divider and a ring.
// Usage:
//   req_* carries one hall edge per item (hall code, ticks since last edge).
//   An item is taken when req_valid is high and req_stall is low; req_stall
//   is low only while the sequencer sits at its idle step.
//   rsp_* carries one result per item: averaged speed, direction, ring full.
//   A result stays in the output register until rsp_stall is low; the
//   sequencer waits before its last step while the previous result is held.
//   csr_* writes speed_scale; csr_ready is always high. Write only when idle.
// Sequence:
//   After taking an item the sequencer divides speed_scale by the ticks into
//   MAG_W = 31 + log2(FILTER_DEPTH) quotient bits, stores the signed speed in
//   the ring, sums the n entries held, divides the sum by n and, once no prior
//   result is held, loads the result register; the next item is taken only
//   once the sequencer is back at its idle step. The restoring divider runs one
//   quotient bit per cycle, twice per item (speed, then mean); each ring entry is read, then added.
// Reset:
//   Synchronous, active high. Clears the sequencer, ring fill index, ring
//   full flag and last position; speed_scale returns to 5000000.
`timescale 1ns / 1ps
`default_nettype none

module hall_speed_direction_filter_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_hall_code,
   input  wire logic [31:0]        req_period_ticks,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_filtered_speed,
   output logic                    rsp_direction_negative,
   output logic                    rsp_window_full,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [31:0]        csr_speed_scale
);
   import hsdf_pkg::*;

   // sequencer
   logic [STEP_W-1:0] pc_ff, pc_in;
   ucode_type         uc;
   logic              jump;
   logic              req_accept;

   // registers
   logic [31:0]              scale_ff;
   logic [MAG_W-1:0]         dq_ff, dq_in;
   logic [31:0]              rem_ff, rem_in;
   logic [31:0]              dvs_ff, dvs_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic [2:0]               code_ff, code_in;
   logic                     tz_ff, tz_in;
   logic                     neg_ff, neg_in;
   logic                     mneg_ff, mneg_in;
   logic [2:0]               last_pos_ff, last_pos_in;
   logic [IDX_W-1:0]         fill_idx_ff, fill_idx_in;
   logic                     filled_ff, filled_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]       rd_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_speed_ff, rsp_speed_in;
   logic                     rsp_dir_ff, rsp_dir_in;
   logic                     rsp_full_ff, rsp_full_in;

   logic signed [31:0] ring_mem [FILTER_DEPTH];

   // datapath helpers
   logic [32:0]             shifted;
   logic                    ge;
   logic [32:0]             diff;
   logic [30:0]             raw_sat;
   logic                    pos_neg;
   logic [2:0]              pos;
   logic signed [31:0]      sval;
   logic                    wrap;
   logic [CNT_W-1:0]        next_rd;
   logic signed [ACC_W-1:0] acc_abs;
   logic [31:0]             q32;

   assign uc         = ucode_rom(pc_ff);
   assign req_stall  = (pc_ff != STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_filtered_speed     = rsp_speed_ff;
   assign rsp_direction_negative = rsp_dir_ff;
   assign rsp_window_full        = rsp_full_ff;

   // restoring divider step
   assign shifted = {rem_ff, dq_ff[MAG_W-1]};
   assign ge      = (shifted >= {1'b0, dvs_ff});
   assign diff    = shifted - {1'b0, dvs_ff};

   // speed quotient saturates at 31 bits; zero ticks gives zero
   assign raw_sat = tz_ff ? 31'd0 :
                    ((dq_ff[MAG_W-1:31] != '0) ? SAT31 : dq_ff[30:0]);
   assign pos     = hall_position(code_ff);
   assign pos_neg = sign_negative(pos, last_pos_ff);
   assign sval    = pos_neg ? -$signed({1'b0, raw_sat}) : $signed({1'b0, raw_sat});
   assign wrap    = (fill_idx_ff == IDX_W'(FILTER_DEPTH - 1));
   assign next_rd = CNT_W'(rd_idx_ff) + CNT_W'(1);
   assign acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   assign q32     = dq_ff[31:0];

   // next step
   always_comb begin
      unique case (uc.cond)
         COND_NONE:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !req_valid;
         COND_DIV_MORE: jump = (iter_ff != '0);
         COND_SUM_MORE: jump = (next_rd < count_ff);
         COND_OUT_BUSY: jump = rsp_valid_ff && rsp_stall;
         default:       jump = 1'b0;
      endcase
      pc_in = jump ? uc.target : pc_ff + STEP_W'(1);
   end

   // datapath control
   always_comb begin
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      iter_in      = iter_ff;
      code_in      = code_ff;
      tz_in        = tz_ff;
      neg_in       = neg_ff;
      mneg_in      = mneg_ff;
      last_pos_in  = last_pos_ff;
      fill_idx_in  = fill_idx_ff;
      filled_in    = filled_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_speed_in = rsp_speed_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_full_in  = rsp_full_ff;
      unique case (uc.op)
         OP_LOAD_SPEED: begin
            if (req_accept) begin
               dq_in   = MAG_W'(scale_ff);
               rem_in  = '0;
               dvs_in  = req_period_ticks;
               iter_in = ITER_W'(MAG_W - 1);
               code_in = req_hall_code;
               tz_in   = (req_period_ticks == '0);
            end
         end
         OP_DIV_STEP: begin
            dq_in   = {dq_ff[MAG_W-2:0], ge};
            rem_in  = ge ? diff[31:0] : shifted[31:0];
            iter_in = iter_ff - ITER_W'(1);
         end
         OP_STORE: begin
            neg_in      = pos_neg;
            last_pos_in = pos;
            fill_idx_in = wrap ? '0 : fill_idx_ff + IDX_W'(1);
            filled_in   = filled_ff || wrap;
            count_in    = (filled_ff || wrap) ? CNT_W'(FILTER_DEPTH)
                                              : CNT_W'(fill_idx_ff) + CNT_W'(1);
            rd_idx_in   = '0;
            acc_in      = '0;
         end
         OP_READ: begin
         end
         OP_ACC: begin
            acc_in    = acc_ff + ACC_W'(rd_data_ff);
            rd_idx_in = rd_idx_ff + IDX_W'(1);
         end
         OP_LOAD_MEAN: begin
            dq_in   = acc_abs[MAG_W-1:0];
            rem_in  = '0;
            dvs_in  = 32'(count_ff);
            iter_in = ITER_W'(MAG_W - 1);
            mneg_in = acc_ff[ACC_W-1];
         end
         OP_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_speed_in = mneg_ff ? -$signed(q32) : $signed(q32);
            rsp_dir_in   = neg_ff;
            rsp_full_in  = filled_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         scale_ff     <= SCALE_RESET;
         last_pos_ff  <= 3'd0;
         fill_idx_ff  <= '0;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         last_pos_ff  <= last_pos_in;
         fill_idx_ff  <= fill_idx_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            scale_ff <= csr_speed_scale;
         end
      end
   end

   always_ff @(posedge clock) begin
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      iter_ff      <= iter_in;
      code_ff      <= code_in;
      tz_ff        <= tz_in;
      neg_ff       <= neg_in;
      mneg_ff      <= mneg_in;
      count_ff     <= count_in;
      rd_idx_ff    <= rd_idx_in;
      acc_ff       <= acc_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // ring of signed raw speeds
   always_ff @(posedge clock) begin
      if (uc.op == OP_STORE) begin
         ring_mem[fill_idx_ff] <= sval;
      end
   end

   always_ff @(posedge clock) begin
      if (uc.op == OP_READ) begin
         rd_data_ff <= ring_mem[rd_idx_ff];
      end
   end

`ifndef SYNTHESIS
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= STEP_FINISH)
      else $error("sequencer step out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_idx_ff <= IDX_W'(FILTER_DEPTH - 1))
      else $error("fill index beyond ring");

   a_filled_sticks: assert property (@(posedge clock) disable iff (reset)
      filled_ff |=> filled_ff)
      else $error("ring full flag cleared");

   a_count_ok: assert property (@(posedge clock) disable iff (reset)
      (uc.op == OP_ACC) |-> (count_ff != '0 && count_ff <= CNT_W'(FILTER_DEPTH)))
      else $error("bad averaging count");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_FINISH) |-> !rsp_valid_ff)
      else $error("result register overwritten");
`endif

endmodule

`default_nettype wire
